>>> hw/rtl/ddgs_pkg.sv
// Package for the diffusion grid step block: operation codes, front-to-back command word,
// sequencer states and fixed-point constants. No dependencies.
package ddgs_pkg;

  localparam int ConcW = 40;
  localparam int RateW = 32;
  localparam int IdxW  = 7;
  localparam int FracW = 24;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] CFG_DIFF = 3'd0;
  localparam logic [2:0] CFG_DECAY = 3'd1;
  localparam logic [2:0] CFG_SRC  = 3'd2;
  localparam logic [2:0] CFG_SROW = 3'd3;
  localparam logic [2:0] CFG_SCOL = 3'd4;

  localparam logic signed [ConcW-1:0] ConcMax = {1'b0, {(ConcW-1){1'b1}}};
  localparam logic signed [ConcW-1:0] ConcMin = {1'b1, {(ConcW-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_STEP,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [RateW-1:0] dt;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic             in_grid;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_STEP,
    ST_COPY,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/ddgs_front.sv
// Front end: accepts input words, classifies the operation and pushes commands into a
// two-entry queue. Depends on ddgs_pkg.
module ddgs_front #(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output ddgs_pkg::cmd_t   cmd
);

  ddgs_pkg::cmd_t q_r [2];
  logic [1:0]     cnt_r;
  logic           wp_r, rp_r;
  ddgs_pkg::cmd_t c;
  logic           push, pop;

  always_comb begin
    c.dt  = in_tdata[33:2];
    c.row = in_tdata[40:34];
    c.col = in_tdata[47:41];
    c.in_grid = (32'(c.row) < 32'(GRID_ROWS)) && (32'(c.col) < 32'(GRID_COLS));
    case (in_tdata[1:0])
      ddgs_pkg::OP_CLEAR: c.kind = ddgs_pkg::KIND_CLEAR;
      ddgs_pkg::OP_STEP:  c.kind = ddgs_pkg::KIND_STEP;
      ddgs_pkg::OP_READ:  c.kind = ddgs_pkg::KIND_READ;
      default:            c.kind = ddgs_pkg::KIND_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wp_r] <= c;
  end

endmodule

>>> hw/rtl/ddgs_back.sv
// Back end: grid memories, the cell sweep with the five-point update, and the result
// register. Depends on ddgs_pkg.
module ddgs_back #(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ddgs_pkg::cmd_t     cmd,
  input  logic [31:0]        diff_rate,
  input  logic [31:0]        decay_rate,
  input  logic [31:0]        src_rate,
  input  logic [6:0]         src_row,
  input  logic [6:0]         src_col,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata,
  output logic [1:0]         out_tuser
);

  localparam int Cells = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(Cells);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int CntW  = $clog2(Cells + 1);

  // Per-cell sequence: five fetch phases on the one read port, the Laplacian, three
  // products split into low and high halves on one shared multiplier, the rate sum and
  // the write.
  typedef enum logic [3:0] {
    P_OLD, P_UP, P_DN, P_LF, P_RT, P_LAP, P_M1L, P_M1H, P_M2L, P_M2H, P_T, P_M3L, P_M3H,
    P_WR
  } ph_t;

  logic signed [39:0] cur_mem [Cells];
  logic signed [39:0] nxt_mem [Cells];

  ddgs_pkg::state_t st_r, st_nxt;
  ph_t              ph_r;
  logic [CntW-1:0]  clr_r;
  logic             clr_busy_r;
  logic [RW-1:0]    r_r;
  logic [CW-1:0]    c_r;
  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic signed [39:0] rd_q_r;
  logic             rd_ok_r, rd_ok;
  logic signed [39:0] old_r, up_r, dn_r, lf_r;
  logic signed [44:0] lap_r;
  logic signed [87:0] p1_r, p2_r, p3_r, acc_r;
  logic signed [53:0] t_r;
  logic             sat_r;
  ddgs_pkg::cmd_t   cmd_r;
  logic [AW-1:0]    cp_r;
  logic [AW-1:0]    cp_wa_r;
  logic signed [39:0] cp_dat_r;
  logic             cp_wr_r;
  logic             last_cell;
  logic             src_ok;
  logic [39:0]      res_data_r;
  logic [1:0]       res_user_r;
  logic             res_valid_r;
  logic signed [53:0] t_nxt;
  logic signed [63:0] q3;
  logic signed [65:0] v;
  logic signed [39:0] v_sat;
  logic             v_hi, v_lo;
  logic [53:0]      m_x;
  logic [31:0]      m_b;
  logic             m_hi;
  logic signed [27:0] m_op;
  logic signed [60:0] m_prod;

  function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(GRID_COLS) + 32'(c);
    return a[AW-1:0];
  endfunction

  assign src_ok = (32'(src_row) >= 32'd1) && (32'(src_row) + 32'd2 <= 32'(GRID_ROWS)) &&
                  (32'(src_col) >= 32'd1) && (32'(src_col) + 32'd2 <= 32'(GRID_COLS));
  assign last_cell = (32'(r_r) == 32'(GRID_ROWS - 1)) && (32'(c_r) == 32'(GRID_COLS - 1));

  // Read address and in-grid flag for the current fetch phase.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr(r_r, c_r);
    rd_ok   = 1'b1;
    if (st_r == ddgs_pkg::ST_STEP) begin
      rd_en = 1'b1;
      case (ph_r)
        P_OLD: rd_addr = addr(r_r, c_r);
        P_UP: begin
          rd_ok   = (r_r != '0);
          rd_addr = addr(r_r - RW'(1), c_r);
        end
        P_DN: begin
          rd_ok   = (32'(r_r) != 32'(GRID_ROWS - 1));
          rd_addr = addr(r_r + RW'(1), c_r);
        end
        P_LF: begin
          rd_ok   = (c_r != '0);
          rd_addr = addr(r_r, c_r - CW'(1));
        end
        P_RT: begin
          rd_ok   = (32'(c_r) != 32'(GRID_COLS - 1));
          rd_addr = addr(r_r, c_r + CW'(1));
        end
        default: rd_en = 1'b0;
      endcase
    end else if (st_r == ddgs_pkg::ST_READ) begin
      rd_en   = 1'b1;
      rd_addr = addr(RW'(cmd_r.row), CW'(cmd_r.col));
    end
  end

  // Memories; the clear pass and the copy-back each take one cell a cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= cur_mem[rd_addr];
    end
    if (st_r == ddgs_pkg::ST_COPY) begin
      cp_dat_r <= nxt_mem[cp_r];
    end
    if (st_r == ddgs_pkg::ST_CLEAR) begin
      cur_mem[clr_r[AW-1:0]] <= '0;
    end else if (cp_wr_r) begin
      cur_mem[cp_wa_r] <= cp_dat_r;
    end
    if (st_r == ddgs_pkg::ST_STEP && ph_r == P_WR) begin
      nxt_mem[addr(r_r, c_r)] <= v_sat;
    end
  end

  // Shared multiplier: one half of a signed operand times an unsigned rate.
  always_comb begin
    m_x = 54'(lap_r);
    m_b = diff_rate;
    case (ph_r)
      P_M2L, P_M2H: begin
        m_x = 54'(old_r);
        m_b = decay_rate;
      end
      P_M3L, P_M3H: begin
        m_x = t_r;
        m_b = cmd_r.dt;
      end
      default: ;
    endcase
    m_hi   = (ph_r == P_M1H) || (ph_r == P_M2H) || (ph_r == P_M3H);
    m_op   = m_hi ? $signed({m_x[53], m_x[53:27]}) : $signed({1'b0, m_x[26:0]});
    m_prod = 61'(m_op) * 61'($signed({1'b0, m_b}));
  end

  always_comb begin
    t_nxt = 54'(p1_r >>> ddgs_pkg::FracW) - 54'(p2_r >>> ddgs_pkg::FracW);
    if (src_ok && 32'(r_r) == 32'(src_row) && 32'(c_r) == 32'(src_col)) begin
      t_nxt = t_nxt + 54'($signed({1'b0, src_rate}));
    end
    q3    = 64'(p3_r >>> ddgs_pkg::FracW);
    v     = 66'(old_r) + 66'(q3);
    v_hi  = v > 66'(ddgs_pkg::ConcMax);
    v_lo  = v < 66'(ddgs_pkg::ConcMin);
    v_sat = v_hi ? ddgs_pkg::ConcMax : (v_lo ? ddgs_pkg::ConcMin : v[39:0]);
  end

  assign cmd_ready = (st_r == ddgs_pkg::ST_IDLE) && !clr_busy_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ddgs_pkg::ST_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.kind)
            ddgs_pkg::KIND_CLEAR: st_nxt = ddgs_pkg::ST_CLEAR;
            ddgs_pkg::KIND_STEP:  st_nxt = ddgs_pkg::ST_STEP;
            ddgs_pkg::KIND_READ:  st_nxt = cmd.in_grid ? ddgs_pkg::ST_READ : ddgs_pkg::ST_DONE;
            default:              st_nxt = ddgs_pkg::ST_DONE;
          endcase
        end
      end
      ddgs_pkg::ST_CLEAR:
        if (clr_r == CntW'(Cells - 1)) begin
          st_nxt = clr_busy_r ? ddgs_pkg::ST_IDLE : ddgs_pkg::ST_DONE;
        end
      ddgs_pkg::ST_STEP:
        if (ph_r == P_WR && last_cell) st_nxt = ddgs_pkg::ST_COPY;
      ddgs_pkg::ST_COPY:
        if (32'(cp_r) == 32'(Cells - 1)) st_nxt = ddgs_pkg::ST_DONE;
      ddgs_pkg::ST_READ: st_nxt = ddgs_pkg::ST_DONE;
      ddgs_pkg::ST_DONE: if (!res_valid_r) st_nxt = ddgs_pkg::ST_IDLE;
      default: st_nxt = ddgs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ddgs_pkg::ST_CLEAR;
      clr_r       <= '0;
      clr_busy_r  <= 1'b1;
      ph_r        <= P_OLD;
      r_r         <= '0;
      c_r         <= '0;
      cp_r        <= '0;
      cp_wr_r     <= 1'b0;
      sat_r       <= 1'b0;
      res_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      cmd_r       <= '0;
    end else begin
      st_r    <= st_nxt;
      rd_ok_r <= rd_ok;
      cp_wr_r <= (st_r == ddgs_pkg::ST_COPY);
      cp_wa_r <= cp_r;
      if (out_tvalid && out_tready) res_valid_r <= 1'b0;
      case (st_r)
        ddgs_pkg::ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cmd_r <= cmd;
            clr_r <= '0;
            r_r   <= '0;
            c_r   <= '0;
            cp_r  <= '0;
            ph_r  <= P_OLD;
            sat_r <= 1'b0;
          end
        end
        ddgs_pkg::ST_CLEAR: begin
          clr_r <= clr_r + CntW'(1);
          if (clr_r == CntW'(Cells - 1)) begin
            clr_busy_r <= 1'b0;
          end
        end
        ddgs_pkg::ST_STEP: begin
          case (ph_r)
            P_OLD: ph_r <= P_UP;
            P_UP: begin old_r <= rd_q_r; ph_r <= P_DN; end
            P_DN: begin up_r <= rd_ok_r ? rd_q_r : '0; ph_r <= P_LF; end
            P_LF: begin dn_r <= rd_ok_r ? rd_q_r : '0; ph_r <= P_RT; end
            P_RT: begin lf_r <= rd_ok_r ? rd_q_r : '0; ph_r <= P_LAP; end
            P_LAP: begin
              lap_r <= 45'(up_r) + 45'(dn_r) + 45'(lf_r) + 45'(rd_ok_r ? rd_q_r : 40'sd0)
                       - (45'(old_r) <<< 2);
              ph_r  <= P_M1L;
            end
            P_M1L: begin acc_r <= 88'(m_prod); ph_r <= P_M1H; end
            P_M1H: begin
              p1_r <= acc_r + (88'(m_prod) <<< 27);
              ph_r <= P_M2L;
            end
            P_M2L: begin acc_r <= 88'(m_prod); ph_r <= P_M2H; end
            P_M2H: begin
              p2_r <= acc_r + (88'(m_prod) <<< 27);
              ph_r <= P_T;
            end
            P_T: begin t_r <= t_nxt; ph_r <= P_M3L; end
            P_M3L: begin acc_r <= 88'(m_prod); ph_r <= P_M3H; end
            P_M3H: begin
              p3_r <= acc_r + (88'(m_prod) <<< 27);
              ph_r <= P_WR;
            end
            P_WR: begin
              if (v_hi || v_lo) sat_r <= 1'b1;
              ph_r <= P_OLD;
              if (32'(c_r) == 32'(GRID_COLS - 1)) begin
                c_r <= '0;
                r_r <= r_r + RW'(1);
              end else begin
                c_r <= c_r + CW'(1);
              end
            end
            default: ph_r <= P_OLD;
          endcase
        end
        ddgs_pkg::ST_COPY: cp_r <= cp_r + AW'(1);
        ddgs_pkg::ST_DONE: begin
          if (!res_valid_r) begin
            res_valid_r <= 1'b1;
            res_data_r  <= (cmd_r.kind == ddgs_pkg::KIND_READ && cmd_r.in_grid) ? rd_q_r : '0;
            res_user_r  <= {(cmd_r.kind == ddgs_pkg::KIND_STEP) && sat_r,
                            cmd_r.kind != ddgs_pkg::KIND_NOP};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_data_r;
  assign out_tuser  = res_user_r;

endmodule

>>> hw/rtl/diffusion_decay_grid_step.sv
// Top level of the diffusion grid step block: configuration registers, front end and
// back end. Depends on ddgs_pkg, ddgs_front and ddgs_back.
//
// Channel | Direction | tdata                                          | tuser
// in_     | slave     | operation[1:0] time_step[33:2] row[40:34] col[47:41] | none
// out_    | master    | read_value[39:0]                               | op_done[0] saturated[1]
// cfg_    | write     | index 0..4, data 32 bits                       | none
//
// A step sweeps every cell: five reads on the single read port of the grid memory, the
// Laplacian, three products in low and high halves on one shared multiplier, the rate sum
// and the write. It then copies the work grid back one cell a cycle.
// Clear writes one cell a cycle.
// After reset the grid is cleared before the first word is run.
// A two-entry queue between the front and back ends lets input words arrive while a
// result waits on out_tready.
module diffusion_decay_grid_step #(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // operation, time_step, row, col
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value
  output logic [1:0]  out_tuser,  // op_done, saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] diff_r, decay_r, src_r;
  logic [6:0]  srow_r, scol_r;
  logic           cmd_valid, cmd_ready;
  ddgs_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r  <= 32'd1677722;
      decay_r <= 32'd2684;
      src_r   <= 32'd8388608;
      srow_r  <= 7'd50;
      scol_r  <= 7'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        ddgs_pkg::CFG_DIFF:  diff_r  <= cfg_data;
        ddgs_pkg::CFG_DECAY: decay_r <= cfg_data;
        ddgs_pkg::CFG_SRC:   src_r   <= cfg_data;
        ddgs_pkg::CFG_SROW:  srow_r  <= cfg_data[6:0];
        ddgs_pkg::CFG_SCOL:  scol_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ddgs_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cmd_valid, .cmd_ready, .cmd
  );

  ddgs_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .diff_rate(diff_r), .decay_rate(decay_r), .src_rate(src_r),
    .src_row(srow_r), .src_col(scol_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

endmodule

>>> hw/rtl/ddgs_checker.sv
// Port checker for the diffusion grid step block, bound to the top level.
// Depends on the top level's ports only.
module ddgs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_sat_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("saturated without op_done");

  a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0)
    else $error("step result carries read data");

  a_nodone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("unknown operation returned data");

endmodule

bind diffusion_decay_grid_step ddgs_checker u_ddgs_checker (
  .clk, .rst_n,
  .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

>>> tb/diffusion_decay_grid_step_test.sv
// Self-checking testbench for diffusion_decay_grid_step on a small 12 x 10 grid: directed
// words, then random words under four idling phases, checked against fixed expectations or a grid predictor.
// Depends on ddgs_pkg and the RTL of the block.
`timescale 1ns / 100ps

module diffusion_decay_grid_step_test;

  localparam int Rows = 12;
  localparam int Cols = 10;
  localparam int Cells = Rows * Cols;
  localparam int IdleLimit = 40000;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [1:0] OpUnknown = 2'd3;

  typedef struct {
    logic [39:0] value;
    logic        done;
    logic        sat;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] dt;
    logic [6:0]  row;
    logic [6:0]  col;
    bit          typed;
    logic [39:0] value;
    logic        done;
    logic        sat;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // operation, time_step, row, col
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // read_value
  logic [1:0]  out_tuser;      // op_done, saturated
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [39:0] grid [Cells];
  logic [31:0] diff_rate, decay_rate, src_rate;
  logic [6:0]  src_row, src_col;

  result_t pending_q[$];
  int      errors = 0;
  int      words_seen = 0;
  int      idle_cycles = 0;
  int      idle_mode = 0;
  int      steps_sent = 0;
  int      sats_seen = 0;

  always #10 clk = ~clk;

  diffusion_decay_grid_step #(.GRID_ROWS(Rows), .GRID_COLS(Cols)) dut (.*);

  function automatic logic signed [127:0] mul_q24(logic signed [127:0] a, logic [31:0] b);
    logic signed [127:0] bb;
    bb = signed'({96'd0, b});
    return (a * bb) >>> ddgs_pkg::FracW;
  endfunction

  function automatic logic signed [127:0] cell_at(int r, int c);
    if (r < 0 || c < 0 || r >= Rows || c >= Cols) return '0;
    return 128'(grid[r * Cols + c]);
  endfunction

  function automatic logic advance_grid(logic [31:0] dt);
    logic signed [39:0]  next_cells [Cells];
    logic signed [127:0] old, lap, t, v;
    logic sat;
    logic src_ok;
    sat = 1'b0;
    src_ok = src_row >= 1 && int'(src_row) + 2 <= Rows &&
             src_col >= 1 && int'(src_col) + 2 <= Cols;
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        old = cell_at(r, c);
        lap = cell_at(r - 1, c) + cell_at(r + 1, c) + cell_at(r, c - 1) + cell_at(r, c + 1)
              - 4 * old;
        t = mul_q24(lap, diff_rate) - mul_q24(old, decay_rate);
        if (src_ok && r == int'(src_row) && c == int'(src_col)) begin
          t = t + signed'({96'd0, src_rate});
        end
        v = old + mul_q24(t, dt);
        if (v > 128'(ddgs_pkg::ConcMax)) begin
          v = 128'(ddgs_pkg::ConcMax);
          sat = 1'b1;
        end
        if (v < 128'(ddgs_pkg::ConcMin)) begin
          v = 128'(ddgs_pkg::ConcMin);
          sat = 1'b1;
        end
        next_cells[r * Cols + c] = v[39:0];
      end
    end
    grid = next_cells;
    return sat;
  endfunction

  function automatic result_t predict_word(logic [1:0] op, logic [31:0] dt, logic [6:0] row,
                                           logic [6:0] col);
    result_t res;
    res = '{value: '0, done: 1'b0, sat: 1'b0};
    case (op)
      ddgs_pkg::OP_CLEAR: begin
        foreach (grid[i]) grid[i] = '0;
        res.done = 1'b1;
      end
      ddgs_pkg::OP_STEP: begin
        res.sat = advance_grid(dt);
        res.done = 1'b1;
      end
      ddgs_pkg::OP_READ: begin
        res.value = 40'(cell_at(row, col));
        res.done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_word(logic [1:0] op, logic [31:0] dt, logic [6:0] row, logic [6:0] col,
                           bit typed, result_t typed_res);
    result_t res;
    int gap;
    gap = (idle_mode == 1) ? 81 : (idle_mode == 3) ? 13 : 0;
    while ($urandom_range(99) < gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    res = predict_word(op, dt, row, col);
    if (op == ddgs_pkg::OP_STEP) steps_sent++;
    pending_q.push_back(typed ? typed_res : res);
    in_tvalid <= 1'b1;
    in_tdata <= {col, row, dt, op};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    in_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      ddgs_pkg::CFG_DIFF:  diff_rate = data;
      ddgs_pkg::CFG_DECAY: decay_rate = data;
      ddgs_pkg::CFG_SRC:   src_rate = data;
      ddgs_pkg::CFG_SROW:  src_row = data[6:0];
      ddgs_pkg::CFG_SCOL:  src_col = data[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] d, logic [31:0] k, logic [31:0] s, logic [6:0] r,
                         logic [6:0] c);
    write_reg(ddgs_pkg::CFG_DIFF, d);
    write_reg(ddgs_pkg::CFG_DECAY, k);
    write_reg(ddgs_pkg::CFG_SRC, s);
    write_reg(ddgs_pkg::CFG_SROW, {25'd0, r});
    write_reg(ddgs_pkg::CFG_SCOL, {25'd0, c});
  endtask

  always @(posedge clk) begin
    case (idle_mode)
      2:       out_tready <= $urandom_range(99) >= 81;
      3:       out_tready <= $urandom_range(99) >= 13;
      default: out_tready <= 1'b1;
    endcase
  end

  always @(negedge clk) begin
    result_t want;
    if (out_tvalid && out_tready) begin
      words_seen++;
      if (out_tuser[1]) sats_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word value=%h user=%b", $time, out_tdata, out_tuser);
      end else begin
        want = pending_q.pop_front();
        if (out_tdata !== want.value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $time, want.value, out_tdata);
        end
        if (out_tuser[0] !== want.done) begin
          errors++;
          $display("%0t: op_done expected %b actual %b", $time, want.done, out_tuser[0]);
        end
        if (out_tuser[1] !== want.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, want.sat, out_tuser[1]);
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  vector_t directed [11] = '{
    '{ddgs_pkg::OP_READ, 32'd0, 7'd0, 7'd0, 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_READ, 32'd0, 7'd127, 7'd127, 1, 40'd0, 1'b1, 1'b0},
    '{OpUnknown, AllOnes, 7'd127, 7'd127, 1, 40'd0, 1'b0, 1'b0},
    '{ddgs_pkg::OP_STEP, AllOnes, 7'd0, 7'd0, 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_READ, 32'd0, 7'd0, 7'd4, 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_CLEAR, AllOnes, 7'd127, 7'd127, 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_READ, 32'd0, 7'(Rows - 1), 7'(Cols - 1), 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_READ, 32'd0, 7'(Rows), 7'd0, 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_READ, 32'd0, 7'd0, 7'(Cols), 1, 40'd0, 1'b1, 1'b0},
    '{ddgs_pkg::OP_STEP, 32'd0, 7'd0, 7'd0, 0, 40'd0, 1'b0, 1'b0},
    '{OpUnknown, 32'd0, 7'd0, 7'd0, 1, 40'd0, 1'b0, 1'b0}
  };

  initial begin
    result_t typed_res;
    logic [1:0]  op;
    logic [31:0] dt;
    int pick;
    diff_rate = 32'd1677722;
    decay_rate = 32'd2684;
    src_rate = 32'd8388608;
    src_row = 7'd50;
    src_col = 7'd50;
    foreach (grid[i]) grid[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_all(AllOnes, AllOnes, AllOnes, 7'd0, 7'd4);
    foreach (directed[i]) begin
      typed_res = '{value: directed[i].value, done: directed[i].done, sat: directed[i].sat};
      send_word(directed[i].op, directed[i].dt, directed[i].row, directed[i].col,
                directed[i].typed, typed_res);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_all($urandom, $urandom_range(32'h0100_0000), $urandom,
                   7'($urandom_range(1, Rows - 2)), 7'($urandom_range(1, Cols - 2)));
        1: set_all(AllOnes, AllOnes, AllOnes, 7'd127, 7'd127);
        2: set_all(32'd0, 32'd0, AllOnes, 7'd1, 7'(Cols - 2));
        default: set_all($urandom_range(32'h0040_0000), $urandom_range(32'h0010_0000), $urandom,
                         7'(Rows - 2), 7'd1);
      endcase
      idle_mode = phase;
      send_word(ddgs_pkg::OP_CLEAR, $urandom, 7'($urandom), 7'($urandom), 0, typed_res);
      for (int n = 0; n < 25; n++) begin
        pick = $urandom_range(99);
        op = pick < 5 ? ddgs_pkg::OP_CLEAR : pick < 35 ? ddgs_pkg::OP_STEP :
             pick < 90 ? ddgs_pkg::OP_READ : OpUnknown;
        dt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000);
        if ($urandom_range(4) == 0)
          send_word(op, dt, 7'($urandom), 7'($urandom), 0, typed_res);
        else
          send_word(op, dt, 7'($urandom_range(Rows - 1)), 7'($urandom_range(Cols - 1)), 0,
                    typed_res);
      end
    end
    in_tvalid <= 1'b0;
    idle_mode = 0;
    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("Checked %0d result words, %0d of them after grid steps (%0d saturating).",
             words_seen, steps_sent, sats_seen);
    $display("Covered four register settings, all-ones and zero rates, four idling modes.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
